// ===== src/tcc_pkg.sv =====
// shared types, constants and helpers for the text console cursor control
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 256;

    localparam int COLS_W  = 10;
    localparam int ROWS_W  = 9;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 16;
    localparam int OP_W    = 2;
    localparam int TDATA_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW         = 2'd0,
        OP_SCROLL       = 2'd1,
        OP_CLEAR_BOTTOM = 2'd2,
        OP_CLEAR_SCREEN = 2'd3
    } op_t;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_SPC = 8'h20;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_COLUMNS    = 2'd0,
        REG_ROWS       = 2'd1,
        REG_FOREGROUND = 2'd2,
        REG_BACKGROUND = 2'd3
    } reg_idx_t;

    // one queued command group: up to three result transfers
    typedef struct packed {
        logic                 draw;
        logic                 scroll;
        logic                 clear_screen;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [CHAR_W-1:0]    glyph;
        logic [COLOR_W-1:0]   ink;
        logic [COLOR_W-1:0]   paper;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    function automatic logic [COLS_W-1:0] eff_columns(input logic [COLS_W-1:0] c);
        logic [COLS_W-1:0] r;
        r = c;
        if (c == '0) r = COLS_W'(1);
        else if (c > COLS_W'(MAX_COLUMNS)) r = COLS_W'(MAX_COLUMNS);
        return r;
    endfunction

    // bottom row index, eff_rows - 1
    function automatic logic [ROW_W-1:0] bottom_row(input logic [ROWS_W-1:0] r);
        logic [ROWS_W-1:0] e;
        e = r;
        if (r == '0) e = ROWS_W'(1);
        else if (r > ROWS_W'(MAX_ROWS)) e = ROWS_W'(MAX_ROWS);
        e = e - ROWS_W'(1);
        return e[ROW_W-1:0];
    endfunction

endpackage

// ===== src/tcc_front.sv =====
// front end: takes character transfers, moves the cursor and queues commands
`timescale 1ns / 1ps
module tcc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tcc_pkg::CHAR_W-1:0]   s_tdata,
    input  logic [tcc_pkg::COLS_W-1:0]   columns,
    input  logic [tcc_pkg::ROWS_W-1:0]   rows,
    input  logic [tcc_pkg::COLOR_W-1:0]  fg_colour,
    input  logic [tcc_pkg::COLOR_W-1:0]  bg_colour,
    input  tcc_pkg::fifo_stat_t          q_stat,
    output logic                         q_push,
    output tcc_pkg::cmd_t                q_cmd
);
    import tcc_pkg::*;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COLS_W-1:0] eff_c;
    logic [ROW_W-1:0]  bottom;
    logic [COLS_W-1:0] adv_col, tab_col;
    logic [COL_W-1:0]  sb_col;
    logic [ROW_W-1:0]  sb_row;
    logic              nl;
    logic [COL_W-1:0]  nl_col;
    logic              at_bottom;
    logic              accept;

    assign eff_c     = eff_columns(columns);
    assign bottom    = bottom_row(rows);
    assign adv_col   = {1'b0, col_reg} + COLS_W'(1);
    assign tab_col   = {1'b0, col_reg | COL_W'(7)} + COLS_W'(1);
    assign at_bottom = (row_reg >= bottom);
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;

    // step back one cell, wrapping to the end of the previous row
    always_comb begin
        sb_col = col_reg;
        sb_row = row_reg;
        if (col_reg != '0) begin
            sb_col = col_reg - COL_W'(1);
        end else if (row_reg != '0) begin
            sb_col = COL_W'(eff_c - COLS_W'(1));
            sb_row = row_reg - ROW_W'(1);
        end
    end

    always_comb begin
        col_next           = col_reg;
        row_next           = row_reg;
        nl                 = 1'b0;
        nl_col             = '0;
        q_cmd.draw         = 1'b0;
        q_cmd.scroll       = 1'b0;
        q_cmd.clear_screen = 1'b0;
        q_cmd.col          = col_reg;
        q_cmd.row          = row_reg;
        q_cmd.glyph        = s_tdata;
        q_cmd.ink          = fg_colour;
        q_cmd.paper        = bg_colour;
        unique case (s_tdata) inside
            CH_NUL, CH_CR: begin
            end
            CH_BS: begin
                col_next = sb_col;
                row_next = sb_row;
            end
            CH_TAB: begin
                if (tab_col >= eff_c) nl = 1'b1;
                else col_next = tab_col[COL_W-1:0];
            end
            CH_LF: nl = 1'b1;
            CH_VT: begin
                nl     = 1'b1;
                nl_col = col_reg;
            end
            CH_FF: begin
                col_next           = '0;
                row_next           = '0;
                q_cmd.clear_screen = 1'b1;
            end
            CH_DEL: begin
                col_next    = sb_col;
                row_next    = sb_row;
                q_cmd.draw  = 1'b1;
                q_cmd.col   = sb_col;
                q_cmd.row   = sb_row;
                q_cmd.glyph = CH_SPC;
            end
            default: begin
                q_cmd.draw = 1'b1;
                if (adv_col >= eff_c) nl = 1'b1;
                else col_next = adv_col[COL_W-1:0];
            end
        endcase
        // new line: scroll at or below the bottom row
        if (nl) begin
            col_next = nl_col;
            if (at_bottom) begin
                row_next     = bottom;
                q_cmd.scroll = 1'b1;
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    assign q_push = accept && (q_cmd.draw || q_cmd.scroll || q_cmd.clear_screen);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== src/tcc_fifo.sv =====
// two-entry command queue between front and back end
`timescale 1ns / 1ps
module tcc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tcc_pkg::cmd_t        wr_cmd,
    input  logic                 pop,
    output tcc_pkg::cmd_t        rd_cmd,
    output tcc_pkg::fifo_stat_t  stat
);
    import tcc_pkg::*;

    cmd_t        mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_cmd     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= wr_cmd;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty queue");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== src/tcc_back.sv =====
// back end: expands queued commands into result transfers
`timescale 1ns / 1ps
module tcc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcc_pkg::fifo_stat_t           q_stat,
    input  tcc_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tcc_pkg::TDATA_W-1:0]   m_tdata,
    output logic [tcc_pkg::OP_W-1:0]      m_tuser,
    output logic                          m_tlast
);
    import tcc_pkg::*;

    // pending bits: draw, scroll, clear bottom, clear screen
    logic [3:0]          pend_reg, pend_next, pend_after, pend_rem;
    cmd_t                cur_reg, cur_next;
    logic                vld_reg, vld_next;
    op_t                 op_reg, op_next, op_sel;
    logic [TDATA_W-1:0]  data_reg, data_next;
    logic                last_reg, last_next;
    logic                out_free, emit;

    assign out_free = !vld_reg || m_tready;
    assign emit     = out_free && (pend_reg != '0);

    always_comb begin
        pend_after = pend_reg;
        op_sel     = OP_DRAW;
        if (pend_reg[0]) begin
            op_sel        = OP_DRAW;
            pend_after[0] = 1'b0;
        end else if (pend_reg[1]) begin
            op_sel        = OP_SCROLL;
            pend_after[1] = 1'b0;
        end else if (pend_reg[2]) begin
            op_sel        = OP_CLEAR_BOTTOM;
            pend_after[2] = 1'b0;
        end else begin
            op_sel        = OP_CLEAR_SCREEN;
            pend_after[3] = 1'b0;
        end
        pend_rem = emit ? pend_after : pend_reg;
        // reload from the queue as soon as the last pending item leaves
        q_pop     = !q_stat.empty && (pend_rem == '0);
        pend_next = pend_rem;
        cur_next  = cur_reg;
        if (q_pop) begin
            pend_next = {q_cmd.clear_screen, q_cmd.scroll, q_cmd.scroll, q_cmd.draw};
            cur_next  = q_cmd;
        end
    end

    always_comb begin
        vld_next  = vld_reg && !m_tready;
        op_next   = op_reg;
        data_next = data_reg;
        last_next = last_reg;
        if (emit) begin
            vld_next  = 1'b1;
            op_next   = op_sel;
            last_next = (pend_after == '0);
            data_next = '0;
            if (op_sel == OP_DRAW) begin
                data_next = TDATA_W'({cur_reg.paper, cur_reg.ink, cur_reg.glyph,
                                      cur_reg.row, cur_reg.col});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            vld_reg  <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        op_reg   <= op_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = op_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTH
    a_cls_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg[3] |-> (pend_reg[2:0] == 3'b000))
        else $error("clear screen queued with other commands");
    a_scroll_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg[1] |-> pend_reg[2])
        else $error("scroll pending without bottom row clear");
    a_clear_bottom_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && op_reg == OP_CLEAR_BOTTOM) |-> last_reg)
        else $error("clear bottom not marked last");
`endif

endmodule

// ===== src/text_console_cursor_control.sv =====
// top level of the text console cursor control with its register file
//
//  channel   dir  handshake                  payload
//  s_        in   s_tvalid / s_tready        s_tdata: character
//  m_        out  m_tvalid / m_tready        m_tdata, m_tuser: operation, m_tlast
//  apb       in   psel / penable / pready    paddr, pwdata, prdata
//
// one character is accepted per cycle while the command queue has room
// each command group leaves as one to three transfers, one per cycle while m_tready is high
// a character's result passes the queue, pending bits and output register
// reset is synchronous and clears the cursor, queue and output stage
// a stalled m_ side fills the output register, the pending command and the
// two-entry queue before s_tready drops
`timescale 1ns / 1ps
module text_console_cursor_control (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcc_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] character
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [8:0] cell_column, [16:9] cell_row, [24:17] glyph_code,
    // [40:25] ink_colour, [56:41] paper_colour, [63:57] zero
    output logic [tcc_pkg::TDATA_W-1:0]   m_tdata,
    output logic [tcc_pkg::OP_W-1:0]      m_tuser,   // [1:0] operation
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tcc_pkg::*;

    logic [COLS_W-1:0]  columns_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic               wr_en;
    reg_idx_t           wr_idx, rd_idx;
    fifo_stat_t         q_stat;
    cmd_t               push_cmd, pop_cmd;
    logic               q_push, q_pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign rd_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLS_W'(80);
            rows_reg    <= ROWS_W'(30);
            fg_reg      <= 16'hFFFF;
            bg_reg      <= 16'h0000;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_COLUMNS:    columns_reg <= pwdata[COLS_W-1:0];
                REG_ROWS:       rows_reg    <= pwdata[ROWS_W-1:0];
                REG_FOREGROUND: fg_reg      <= pwdata[COLOR_W-1:0];
                REG_BACKGROUND: bg_reg      <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rd_idx)
            REG_COLUMNS:    prdata = 32'(columns_reg);
            REG_ROWS:       prdata = 32'(rows_reg);
            REG_FOREGROUND: prdata = 32'(fg_reg);
            REG_BACKGROUND: prdata = 32'(bg_reg);
            default:        prdata = '0;
        endcase
    end

    tcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .columns   (columns_reg),
        .rows      (rows_reg),
        .fg_colour (fg_reg),
        .bg_colour (bg_reg),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    tcc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_cmd  (push_cmd),
        .pop     (q_pop),
        .rd_cmd  (pop_cmd),
        .stat    (q_stat)
    );

    tcc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
